>>> rtl/assert_macros.svh
// Shared assertion macros for the solver checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored during rst.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and ignored during rst.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tds_pkg.sv
// ----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared types, widths and saturation helper for the Q16.16 solver.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int DATA_W = 32;
  localparam int ROW_W  = 6;
  localparam int QDEPTH = 2;
  localparam int SAT_W  = 49;

  typedef logic signed [DATA_W-1:0] q_t;

  typedef struct packed {
    q_t             sub_diag;
    q_t             diag;
    q_t             super_diag;
    q_t             rhs;
    logic [ROW_W-1:0] row;
    logic           run_end;
  } row_item_t;

  typedef struct packed {
    q_t pivot;
    q_t upper;
    q_t rhs;
  } store_word_t;

  typedef struct packed {
    logic start;
    q_t   num;
    q_t   den;
  } div_req_t;

  typedef struct packed {
    logic done;
    q_t   quo;
    logic ovf;
  } div_rsp_t;

  typedef struct packed {
    q_t   val;
    logic ovf;
  } sat_t;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_W'(64'sd2147483648);

  function automatic sat_t sat_q(input logic signed [SAT_W-1:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val = q_t'(SAT_MAX[DATA_W-1:0]);
      r.ovf = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = q_t'(SAT_MIN[DATA_W-1:0]);
      r.ovf = 1'b1;
    end else begin
      r.val = q_t'(v[DATA_W-1:0]);
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/tds_if.sv
// ----------------------------------------------------------------------------
// Solver channel interfaces
// Valid/ready channels for matrix rows in and solution words out.
// ----------------------------------------------------------------------------
interface tds_in_if;
  import tds_pkg::*;
  logic valid;
  logic ready;
  q_t   sub_diag;
  q_t   diag;
  q_t   super_diag;
  q_t   rhs;
  logic last_row;
  modport source (output valid, sub_diag, diag, super_diag, rhs, last_row, input ready);
  modport sink (input valid, sub_diag, diag, super_diag, rhs, last_row, output ready);
endinterface

interface tds_out_if;
  import tds_pkg::*;
  logic             valid;
  logic             ready;
  q_t               solution;
  logic [ROW_W-1:0] row_index;
  logic             last_result;
  logic             pivot_error;
  modport source (output valid, solution, row_index, last_result, pivot_error, input ready);
  modport sink (input valid, solution, row_index, last_result, pivot_error, output ready);
endinterface

>>> rtl/tds_front.sv
// ----------------------------------------------------------------------------
// Solver front end
// Accepts rows, numbers them, marks the last row of each run and queues them.
// ----------------------------------------------------------------------------
module tds_front #(
  parameter int MAX_ROWS = 64
) (
  input  logic               clk,
  input  logic               rst,
  tds_in_if.sink             rows,
  output logic               q_valid,
  output tds_pkg::row_item_t q_item,
  input  logic               q_pop
);
  import tds_pkg::*;

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PTR_W = $clog2(QDEPTH);

  row_item_t        entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic [IDX_W-1:0] row_cnt;
  logic             push;
  logic             pop;
  logic             run_end;

  assign rows.ready = (count != (PTR_W+1)'(QDEPTH));
  assign push       = rows.valid && rows.ready;
  assign pop        = q_pop && q_valid;
  assign q_valid    = (count != '0);
  assign q_item     = entries[rd_ptr];

  // A full store forces the solve even without the last-row mark.
  assign run_end = rows.last_row || (row_cnt == IDX_W'(MAX_ROWS - 1));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{sub_diag: rows.sub_diag, diag: rows.diag,
                           super_diag: rows.super_diag, rhs: rows.rhs,
                           row: ROW_W'(row_cnt), run_end: run_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      row_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr  <= wr_ptr + 1'b1;
        row_cnt <= run_end ? '0 : row_cnt + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

>>> rtl/tds_div.sv
// ----------------------------------------------------------------------------
// Q16.16 divider
// Restoring radix-2 divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module tds_div (
  input  logic              clk,
  input  logic              rst,
  input  tds_pkg::div_req_t req,
  output tds_pkg::div_rsp_t rsp
);
  import tds_pkg::*;

  localparam int QW = DATA_W + 16;

  logic [QW-1:0]          qsh;
  logic [DATA_W-1:0]      rem;
  logic [DATA_W-1:0]      dmag;
  logic [$clog2(QW)-1:0]  cnt;
  logic                   busy;
  logic                   fin;
  logic                   neg;
  logic                   zero;
  logic [DATA_W:0]        trial;
  logic                   ge;
  logic [DATA_W-1:0]      nmag;
  logic signed [SAT_W-1:0] sval;
  sat_t                   fres;

  assign trial = {rem, qsh[QW-1]};
  assign ge    = (trial >= {1'b0, dmag});
  assign nmag  = req.num[DATA_W-1] ? DATA_W'(-req.num) : DATA_W'(req.num);
  assign sval  = neg ? -$signed({1'b0, qsh}) : $signed({1'b0, qsh});
  assign fres  = sat_q(sval);

  always_ff @(posedge clk) begin
    if (req.start) begin
      qsh  <= {nmag, 16'b0};
      rem  <= '0;
      dmag <= req.den[DATA_W-1] ? DATA_W'(-req.den) : DATA_W'(req.den);
      neg  <= req.num[DATA_W-1] ^ req.den[DATA_W-1];
      zero <= (req.den == '0);
      cnt  <= $clog2(QW)'(QW - 1);
    end else if (busy) begin
      rem <= ge ? DATA_W'(trial - {1'b0, dmag}) : trial[DATA_W-1:0];
      qsh <= {qsh[QW-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // A zero divisor gives zero and no overflow.
  assign rsp.done = fin;
  assign rsp.quo  = zero ? '0 : fres.val;
  assign rsp.ovf  = zero ? 1'b0 : fres.ovf;

endmodule

>>> rtl/tds_back.sv
// ----------------------------------------------------------------------------
// Solver back end
// Forward elimination per row, then back substitution over the stored rows.
// ----------------------------------------------------------------------------
module tds_back #(
  parameter int MAX_ROWS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  tds_pkg::row_item_t q_item,
  output logic               q_pop,
  tds_out_if.source          results
);
  import tds_pkg::*;

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_FRD  = 10'b00_0000_0010,
    S_FST  = 10'b00_0000_0100,
    S_FDIV = 10'b00_0000_1000,
    S_FMUL = 10'b00_0001_0000,
    S_FWR  = 10'b00_0010_0000,
    S_BRD  = 10'b00_0100_0000,
    S_BNUM = 10'b00_1000_0000,
    S_BSUB = 10'b01_0000_0000,
    S_BDIV = 10'b10_0000_0000
  } state_t;

  state_t             state;
  state_t             state_next;
  store_word_t        mem [MAX_ROWS];
  store_word_t        rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  row_item_t          cur;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   top_idx;
  logic               err_seen;
  logic               div_ovf;
  q_t                 m;
  q_t                 x;
  logic signed [63:0] prod_u;
  logic signed [63:0] prod_d;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic               out_free;
  logic               out_wait;
  store_word_t        wr_word;
  logic               wr_ovf;
  sat_t               mu;
  sat_t               md;
  sat_t               pu;
  sat_t               pd;
  sat_t               bm;
  sat_t               bn;

  tds_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign out_free = !results.valid || results.ready;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign rd_en    = (state == S_FRD) || (state == S_BRD);
  assign rd_addr  = (state == S_FRD) ? cur.row[IDX_W-1:0] - 1'b1 : idx;

  // Forward elimination result for the current row.
  always_comb begin
    mu = sat_q(SAT_W'($signed(prod_u[63:16])));
    md = sat_q(SAT_W'($signed(prod_d[63:16])));
    pu = sat_q(SAT_W'(cur.diag) - SAT_W'(mu.val));
    pd = sat_q(SAT_W'(cur.rhs) - SAT_W'(md.val));
    if (cur.row == '0) begin
      wr_word = '{pivot: cur.diag, upper: cur.super_diag, rhs: cur.rhs};
      wr_ovf  = 1'b0;
    end else begin
      wr_word = '{pivot: pu.val, upper: cur.super_diag, rhs: pd.val};
      wr_ovf  = div_ovf || mu.ovf || pu.ovf;
    end
  end

  // Back substitution numerator: d'_i - c_i * x(i+1).
  always_comb begin
    bm = sat_q(SAT_W'($signed(prod_u[63:16])));
    bn = sat_q(SAT_W'(rd_data.rhs) - SAT_W'(bm.val));
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = rd_data.rhs;
    dreq.den   = rd_data.pivot;
    unique case (state)
      S_FST: begin
        dreq.start = 1'b1;
        dreq.num   = cur.sub_diag;
      end
      S_BNUM: begin
        dreq.start = (idx == top_idx);
      end
      S_BSUB: begin
        dreq.start = 1'b1;
        dreq.num   = bn.val;
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid) state_next = (q_item.row == '0) ? S_FWR : S_FRD;
      S_FRD:  state_next = S_FST;
      S_FST:  state_next = S_FDIV;
      S_FDIV: if (drsp.done) state_next = S_FMUL;
      S_FMUL: state_next = S_FWR;
      S_FWR:  state_next = cur.run_end ? S_BRD : S_IDLE;
      S_BRD:  state_next = S_BNUM;
      S_BNUM: state_next = (idx == top_idx) ? S_BDIV : S_BSUB;
      S_BSUB: state_next = S_BDIV;
      S_BDIV: begin
        if (out_wait && out_free) begin
          state_next = (idx == '0) ? S_IDLE : S_BRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (state == S_FWR) begin
      mem[cur.row[IDX_W-1:0]] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == S_FDIV && drsp.done) begin
      m       <= drsp.quo;
      div_ovf <= drsp.ovf;
    end
    if (state == S_FMUL) begin
      prod_u <= 64'(m) * 64'(rd_data.upper);
      prod_d <= 64'(m) * 64'(rd_data.rhs);
    end
    if (state == S_BNUM) begin
      prod_u <= 64'(rd_data.upper) * 64'(x);
    end
    if (state == S_BDIV && drsp.done) begin
      x <= drsp.quo;
    end
    if (state == S_FWR) begin
      idx     <= cur.row[IDX_W-1:0];
      top_idx <= cur.row[IDX_W-1:0];
    end else if (state == S_BDIV && out_wait && out_free && idx != '0) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_BDIV && out_wait && out_free) begin
      results.solution    <= x;
      results.row_index   <= ROW_W'(idx);
      results.last_result <= (idx == '0);
      results.pivot_error <= err_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      err_seen      <= 1'b0;
      out_wait      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FWR) begin
        err_seen <= err_seen || wr_ovf || (wr_word.pivot == '0);
      end
      // The quotient waits here while the output register is still full.
      if (state == S_BDIV && drsp.done) begin
        out_wait <= 1'b1;
      end else if (out_wait && out_free) begin
        out_wait <= 1'b0;
      end
      if (state == S_BDIV && out_wait && out_free) begin
        results.valid <= 1'b1;
        if (idx == '0) begin
          err_seen <= 1'b0;
        end
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/tridiagonal_system_solver_top.sv
// Row 0 is stored without a divide; every later row waits on the
// 48-step radix-2 divider that forms its multiplier.
// A solve emits one word per row, each waiting on its own divide.
// Two queued rows let the input run ahead of the back end.
// Synchronous active-high reset clears the control state; the row stores are
// not cleared and are only read after being written in the same run.
module tridiagonal_system_solver_top #(
  parameter int MAX_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst,
  tds_in_if.sink     rows,
  tds_out_if.source  results
);
  import tds_pkg::*;

  logic      q_valid;
  logic      q_pop;
  row_item_t q_item;

  tds_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .rows    (rows),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  tds_back #(.MAX_ROWS(MAX_ROWS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

>>> rtl/tds_checker.sv
// ----------------------------------------------------------------------------
// Solver port checker
// Watches the result channel for ordering and run consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tds_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [tds_pkg::ROW_W-1:0] row_index,
  input logic                     last_result,
  input logic                     pivot_error,
  input logic [tds_pkg::DATA_W-1:0] solution
);
  import tds_pkg::*;

  logic             in_run;
  logic [ROW_W-1:0] run_idx;
  logic             run_err;

  // Remember the last word of an unfinished run.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run  <= 1'b0;
      run_idx <= '0;
      run_err <= 1'b0;
    end else if (out_valid && out_ready) begin
      in_run  <= !last_result;
      run_idx <= row_index;
      run_err <= pivot_error;
    end
  end

  `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(solution) && $stable(row_index), "result word changed while stalled")
  `ASSERT_SAME(a_last_row0, out_valid && last_result, row_index == '0, "last word is not row 0")
  `ASSERT_SAME(a_row_order, out_valid && in_run, (row_index + 1'b1) == run_idx, "rows not descending by one")
  `ASSERT_SAME(a_err_const, out_valid && in_run, pivot_error == run_err, "error flag changed within a run")

endmodule

bind tridiagonal_system_solver_top tds_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .row_index   (results.row_index),
  .last_result (results.last_result),
  .pivot_error (results.pivot_error),
  .solution    (results.solution)
);

>>> tb/sv/tridiagonal_system_solver_top_test.sv
// ----------------------------------------------------------------------------
// Tridiagonal solver testbench
// Drives matrix rows into the solver, predicts each solution word with a
// Q16.16 Thomas elimination and back substitution model, and checks every
// output word in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver_top_test;
  import tds_pkg::*;

  localparam int NROWS      = 64;
  localparam int STALL_SPAN = 3000;
  localparam int WD_LIMIT   = 20000;

  typedef struct packed {
    q_t               solution;
    logic [ROW_W-1:0] row_index;
    logic             last_result;
    logic             pivot_error;
  } sol_word_t;

  class solve_board;
    q_t        piv_mem[NROWS];
    q_t        up_mem[NROWS];
    q_t        rhs_mem[NROWS];
    int        loaded;
    bit        err_flag;
    sol_word_t pending[$];
    int        fails;

    function new();
      loaded   = 0;
      err_flag = 0;
      fails    = 0;
    endfunction

    function q_t clamp(input longint v, inout bit ovf);
      if (v > 64'sd2147483647) begin
        ovf = 1;
        return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
        ovf = 1;
        return 32'sh80000000;
      end
      return q_t'(v);
    endfunction

    // Product in Q16.16, rounded toward minus infinity by the arithmetic shift.
    function q_t fx_mul(input q_t a, input q_t b, inout bit ovf);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp(p >>> 16, ovf);
    endfunction

    function q_t fx_div(input q_t a, input q_t b, inout bit ovf);
      longint n;
      if (b == 0) return 0;
      n = longint'(a) * 65536;
      return clamp(n / longint'(b), ovf);
    endfunction

    function q_t fx_sub(input q_t a, input q_t b, inout bit ovf);
      return clamp(longint'(a) - longint'(b), ovf);
    endfunction

    function void note_row(input q_t a, input q_t b, input q_t c, input q_t d,
                           input bit last);
      int        k;
      q_t        m, pv, dd, num, x;
      bit        ovf, junk;
      sol_word_t w;
      k    = loaded;
      ovf  = 0;
      junk = 0;
      x    = 0;
      if (k >= NROWS) k = NROWS - 1;
      if (k == 0) begin
        pv = b;
        dd = d;
      end else begin
        m  = fx_div(a, piv_mem[k-1], ovf);
        pv = fx_sub(b, fx_mul(m, up_mem[k-1], ovf), ovf);
        dd = fx_sub(d, fx_mul(m, rhs_mem[k-1], junk), junk);
      end
      if (ovf || pv == 0) err_flag = 1;
      piv_mem[k] = pv;
      up_mem[k]  = c;
      rhs_mem[k] = dd;
      loaded     = k + 1;
      if (!last && k + 1 < NROWS) return;
      for (int i = k; i >= 0; i--) begin
        num = rhs_mem[i];
        if (i < k) num = fx_sub(num, fx_mul(up_mem[i], x, junk), junk);
        x = fx_div(num, piv_mem[i], junk);
        w.solution    = x;
        w.row_index   = i[ROW_W-1:0];
        w.last_result = (i == 0);
        w.pivot_error = err_flag;
        pending.push_back(w);
      end
      loaded   = 0;
      err_flag = 0;
    endfunction

    function void check_word(input sol_word_t got);
      sol_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected solution word row %0d", got.row_index);
        fails++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.solution !== exp_w.solution) begin
        $error("solution: expected %0h actual %0h", exp_w.solution, got.solution);
        fails++;
      end
      if (got.row_index !== exp_w.row_index) begin
        $error("row_index: expected %0d actual %0d", exp_w.row_index, got.row_index);
        fails++;
      end
      if (got.last_result !== exp_w.last_result) begin
        $error("last_result: expected %0b actual %0b", exp_w.last_result,
               got.last_result);
        fails++;
      end
      if (got.pivot_error !== exp_w.pivot_error) begin
        $error("pivot_error: expected %0b actual %0b", exp_w.pivot_error,
               got.pivot_error);
        fails++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  tds_in_if  rows();
  tds_out_if results();
  solve_board board;
  int  idle_cycles = 0;
  bit  stim_done   = 0;
  bit  hold_off    = 0;

  tridiagonal_system_solver_top #(.MAX_ROWS(NROWS)) dut (
    .clk(clk), .rst(rst), .rows(rows), .results(results)
  );

  always #1 clk = ~clk;

  initial begin
    rows.valid      = 0;
    rows.sub_diag   = 0;
    rows.diag       = 0;
    rows.super_diag = 0;
    rows.rhs        = 0;
    rows.last_row   = 0;
    results.ready   = 0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic q_t any_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      default: return q_t'($urandom);
    endcase
  endfunction

  // Offers one row and holds it until accepted; valid stays high across
  // back-to-back words.
  task automatic send_row(input q_t a, input q_t b, input q_t c, input q_t d,
                          input bit last, input bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      rows.valid <= 0;
      repeat (g) @(negedge clk);
    end
    rows.valid      <= 1;
    rows.sub_diag   <= a;
    rows.diag       <= b;
    rows.super_diag <= c;
    rows.rhs        <= d;
    rows.last_row   <= last;
    @(posedge clk);
    while (!rows.ready) @(posedge clk);
    board.note_row(a, b, c, d, last);
    @(negedge clk);
  endtask

  // A diagonally dominant system with random content.
  task automatic send_system(input int n, input bit no_gap);
    q_t a, b, c, d;
    for (int i = 0; i < n; i++) begin
      a = q_t'($signed($urandom_range(0, 131072)) - 65536);
      c = q_t'($signed($urandom_range(0, 131072)) - 65536);
      b = q_t'($urandom_range(196608, 1048576));
      if ($urandom_range(0, 1)) b = -b;
      d = q_t'($signed($urandom_range(0, 4194304)) - 2097152);
      send_row(a, b, c, d, i == n - 1, no_gap);
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      send_row(any_word(), any_word(), any_word(), any_word(), i == n - 1, 0);
  endtask

  initial begin
    int sent;
    board = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // Extremes, a zero pivot, overflow and the smallest systems.
    send_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 0);
    send_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 0);
    send_row(0, 0, 32'sh10000, 32'sh10000, 0, 0);
    send_row(32'sh10000, 32'sh10000, 0, 32'sh10000, 1, 0);
    send_row(0, 32'sh100, 32'sh7fffffff, 32'sh80000000, 0, 0);
    send_row(32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff, 1, 0);
    send_row(0, 32'sh10000, 32'sh10000, 32'sh10000, 0, 0);
    send_row(32'sh10000, 32'sh10000, 0, 32'sh20000, 1, 0);
    send_system(2, 1);
    send_noise(3);
    // A run that fills the store ends without a last-row mark.
    for (int i = 0; i < NROWS; i++)
      send_row(32'sh4000, 32'sh40000, 32'shffffc000, q_t'($urandom), 0, 1);
    sent = 13 + NROWS;
    // The receiver stalls while the sender keeps pushing a long system.
    hold_off = 1;
    send_system(12, 1);
    sent += 12;
    while (sent < 500) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      if ($urandom_range(0, 5) == 0) send_noise(n);
      else send_system(n, $urandom_range(0, 3) == 0);
      sent += n;
    end
    rows.valid <= 0;
    stim_done = 1;
  end

  initial begin
    int g;
    wait (!rst);
    forever begin
      if (hold_off) begin
        hold_off = 0;
        @(negedge clk);
        results.ready <= 0;
        repeat (STALL_SPAN) @(negedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        @(negedge clk);
        results.ready <= 0;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk);
      results.ready <= 1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    sol_word_t w;
    if (!rst && results.valid && results.ready) begin
      w.solution    = results.solution;
      w.row_index   = results.row_index;
      w.last_result = results.last_result;
      w.pivot_error = results.pivot_error;
      board.check_word(w);
    end
  end

  always @(posedge clk) begin
    if (rst || (rows.valid && rows.ready) || (results.valid && results.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tridiagonal_system_solver_top verification failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.fails == 0 && board.pending.size() == 0)
      $display("tridiagonal_system_solver_top verification clean");
    else
      $display("tridiagonal_system_solver_top verification failed");
    $finish;
  end
endmodule
